### hdl/first_fit_block_allocator_macros.svh
// ----------------------------------------------------------------------------
// first_fit_block_allocator_macros.svh - assertion helpers
// Immediate-implication and next-cycle checks, clocked on clock, off in reset.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
`define FFA_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define FFA_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define FFA_ASSERT_IMPL(name, ante, cons, msg)
`define FFA_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

### hdl/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg - first fit allocator shared definitions
// Field widths, request and status codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ffa_pkg;

   localparam int KIND_W     = 2;
   localparam int SIZE_IN_W  = 17;
   localparam int ADDR_W     = 16;
   localparam int STATUS_W   = 3;
   localparam int ALIGN_BYTES = 4;
   // rounded size: 17-bit request plus alignment padding
   localparam int SIZE_W     = 18;

   localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FREE    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REALLOC = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ARENA_FULL = 3'd1;
   localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_ZERO_SIZE  = 3'd4;

   typedef enum logic [1:0] {
      SCAN_FIND,
      SCAN_MERGE,
      SCAN_ALLOC
   } scan_type;

   typedef enum logic [3:0] {
      CS_IDLE,
      CS_DISPATCH,
      CS_FIND,
      CS_FIND_CHK,
      CS_MERGE,
      CS_MERGE_WR,
      CS_ALLOC,
      CS_ALLOC_A,
      CS_ALLOC_B,
      CS_RESP
   } ctrl_state_type;

   typedef struct packed {
      logic                load;
      logic                scan_start;
      scan_type            mode;
      logic                merge_wr;
      logic                alloc_a;
      logic                alloc_b;
      logic                set_res;
      logic [STATUS_W-1:0] res_code;
      logic                rsp_load;
   } cmd_type;

   typedef struct packed {
      logic              scan_done;
      logic              hit;
      logic [KIND_W-1:0] kind;
      logic              size_zero;
      logic              split;
   } sts_type;

endpackage

### hdl/ffa_req_if.sv
// ----------------------------------------------------------------------------
// ffa_req_if - request channel
// Valid/ready channel carrying one allocator request per beat.
// ----------------------------------------------------------------------------
interface ffa_req_if;
   logic                               valid;
   logic                               ready;
   logic [ffa_pkg::KIND_W-1:0]         kind;
   logic [ffa_pkg::SIZE_IN_W-1:0]      req_size;
   logic [ffa_pkg::ADDR_W-1:0]         req_addr;

   modport source (output valid, kind, req_size, req_addr, input ready);
   modport sink   (input valid, kind, req_size, req_addr, output ready);
endinterface

### hdl/ffa_rsp_if.sv
// ----------------------------------------------------------------------------
// ffa_rsp_if - response channel
// Valid/ready channel carrying one grant and status per beat.
// ----------------------------------------------------------------------------
interface ffa_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [ffa_pkg::ADDR_W-1:0]         grant_addr;
   logic [ffa_pkg::STATUS_W-1:0]       status;

   modport source (output valid, grant_addr, status, input ready);
   modport sink   (input valid, grant_addr, status, output ready);
endinterface

### hdl/ffa_ctrl.sv
// ----------------------------------------------------------------------------
// ffa_ctrl - allocator sequencer
// Steps each request through the find, merge and alloc table scans its kind needs.
// ----------------------------------------------------------------------------
module ffa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              out_free,
   input  ffa_pkg::sts_type  sts,
   output ffa_pkg::cmd_type  cmd
);

   ffa_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffa_pkg::CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.mode     = ffa_pkg::SCAN_FIND;
      cmd.res_code = ffa_pkg::ST_OK;
      unique case (state_ff)
         ffa_pkg::CS_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ffa_pkg::CS_DISPATCH;
            end
         end
         ffa_pkg::CS_DISPATCH: begin
            priority if (sts.kind == ffa_pkg::KIND_ALLOC) begin
               if (sts.size_zero) begin
                  cmd.set_res  = 1'b1;
                  cmd.res_code = ffa_pkg::ST_ZERO_SIZE;
                  state_in     = ffa_pkg::CS_RESP;
               end else begin
                  cmd.scan_start = 1'b1;
                  cmd.mode       = ffa_pkg::SCAN_ALLOC;
                  state_in       = ffa_pkg::CS_ALLOC;
               end
            end else if (sts.kind == ffa_pkg::KIND_FREE ||
                         sts.kind == ffa_pkg::KIND_REALLOC) begin
               cmd.scan_start = 1'b1;
               cmd.mode       = ffa_pkg::SCAN_FIND;
               state_in       = ffa_pkg::CS_FIND;
            end else begin
               // unused kind: plain ok, nothing changes
               cmd.set_res  = 1'b1;
               cmd.res_code = ffa_pkg::ST_OK;
               state_in     = ffa_pkg::CS_RESP;
            end
         end
         ffa_pkg::CS_FIND: begin
            if (sts.scan_done) begin
               state_in = ffa_pkg::CS_FIND_CHK;
            end
         end
         ffa_pkg::CS_FIND_CHK: begin
            if (!sts.hit) begin
               cmd.set_res  = 1'b1;
               cmd.res_code = ffa_pkg::ST_NOT_FOUND;
               state_in     = ffa_pkg::CS_RESP;
            end else begin
               cmd.scan_start = 1'b1;
               cmd.mode       = ffa_pkg::SCAN_MERGE;
               state_in       = ffa_pkg::CS_MERGE;
            end
         end
         ffa_pkg::CS_MERGE: begin
            if (sts.scan_done) begin
               state_in = ffa_pkg::CS_MERGE_WR;
            end
         end
         ffa_pkg::CS_MERGE_WR: begin
            cmd.merge_wr = 1'b1;
            priority if (sts.kind == ffa_pkg::KIND_FREE) begin
               cmd.set_res  = 1'b1;
               cmd.res_code = ffa_pkg::ST_OK;
               state_in     = ffa_pkg::CS_RESP;
            end else if (sts.size_zero) begin
               cmd.set_res  = 1'b1;
               cmd.res_code = ffa_pkg::ST_ZERO_SIZE;
               state_in     = ffa_pkg::CS_RESP;
            end else begin
               cmd.scan_start = 1'b1;
               cmd.mode       = ffa_pkg::SCAN_ALLOC;
               state_in       = ffa_pkg::CS_ALLOC;
            end
         end
         ffa_pkg::CS_ALLOC: begin
            if (sts.scan_done) begin
               state_in = ffa_pkg::CS_ALLOC_A;
            end
         end
         ffa_pkg::CS_ALLOC_A: begin
            cmd.alloc_a = 1'b1;
            state_in    = sts.split ? ffa_pkg::CS_ALLOC_B : ffa_pkg::CS_RESP;
         end
         ffa_pkg::CS_ALLOC_B: begin
            cmd.alloc_b = 1'b1;
            state_in    = ffa_pkg::CS_RESP;
         end
         ffa_pkg::CS_RESP: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ffa_pkg::CS_IDLE;
            end
         end
         default: begin
            state_in = ffa_pkg::CS_IDLE;
         end
      endcase
   end

endmodule

### hdl/ffa_dp.sv
// ----------------------------------------------------------------------------
// ffa_dp - allocator segment table and scan datapath
// Segment memory, valid/in-use flags, scan counter, match trackers, updates.
// ----------------------------------------------------------------------------
`include "first_fit_block_allocator_macros.svh"

module ffa_dp #(
   parameter int ARENA_BYTES  = 65536,
   parameter int MAX_SEGMENTS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ffa_pkg::cmd_type                cmd,
   output ffa_pkg::sts_type                sts,
   input  logic [ffa_pkg::KIND_W-1:0]      req_kind,
   input  logic [ffa_pkg::SIZE_IN_W-1:0]   req_size,
   input  logic [ffa_pkg::ADDR_W-1:0]      req_addr,
   output logic [ffa_pkg::ADDR_W-1:0]      res_grant,
   output logic [ffa_pkg::STATUS_W-1:0]    res_status
);

   localparam int IDX_W   = $clog2(MAX_SEGMENTS);
   localparam int START_W = $clog2(ARENA_BYTES);
   localparam int LEN_W   = $clog2(ARENA_BYTES + 1);
   localparam int CW      = ((LEN_W > ffa_pkg::SIZE_W) ? LEN_W : ffa_pkg::SIZE_W) + 1;
   localparam int AW      = (START_W > ffa_pkg::ADDR_W) ? START_W : ffa_pkg::ADDR_W;
   localparam int ENTRY_W = START_W + LEN_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_SEGMENTS - 1);
   localparam logic [CW-1:0]    ARENA_LIM = CW'(ARENA_BYTES);
   localparam logic [ffa_pkg::SIZE_W-1:0] ALIGN_MASK =
      ffa_pkg::SIZE_W'(ffa_pkg::ALIGN_BYTES - 1);

   // request
   logic [ffa_pkg::KIND_W-1:0]   kind_ff;
   logic [ffa_pkg::SIZE_W-1:0]   size_ff;
   logic [ffa_pkg::ADDR_W-1:0]   addr_ff;
   logic                         size_zero_ff;
   logic [ffa_pkg::SIZE_W-1:0]   size_in;

   // table
   logic [ENTRY_W-1:0]           mem [MAX_SEGMENTS];
   logic [MAX_SEGMENTS-1:0]      valid_ff;
   logic [MAX_SEGMENTS-1:0]      inuse_ff;
   logic [LEN_W-1:0]             top_ff;

   // scan pipe
   logic                         iss_ff;
   logic [IDX_W-1:0]             cnt_ff;
   logic                         pv_ff;
   logic [IDX_W-1:0]             pidx_ff;
   logic [ENTRY_W-1:0]           rd_ff;
   ffa_pkg::scan_type            mode_ff;

   // trackers
   logic                         hit_ff, lft_hit_ff, rgt_hit_ff, fit_hit_ff, emp_hit_ff;
   logic [IDX_W-1:0]             hit_idx_ff, lft_idx_ff, rgt_idx_ff, fit_idx_ff, emp_idx_ff;
   logic [START_W-1:0]           hit_start_ff, lft_start_ff, fit_start_ff;
   logic [LEN_W-1:0]             hit_len_ff, lft_len_ff, rgt_len_ff, fit_len_ff;

   logic [ffa_pkg::ADDR_W-1:0]   res_grant_ff;
   logic [ffa_pkg::STATUS_W-1:0] res_status_ff;

   // current entry
   logic [START_W-1:0] cur_start;
   logic [LEN_W-1:0]   cur_len;
   logic               cur_valid, cur_inuse;
   logic               find_match, free_other, left_match, right_match, fits, better;
   logic               split;
   logic               grow_over;

   // merge result
   logic [IDX_W-1:0]   f_idx;
   logic [START_W-1:0] f_start;
   logic [LEN_W-1:0]   f_len;

   // write port
   logic               wr_en;
   logic [IDX_W-1:0]   wr_idx;
   logic [ENTRY_W-1:0] wr_data;

   assign size_in = (ffa_pkg::SIZE_W'(req_size) + ALIGN_MASK) & ~ALIGN_MASK;

   assign cur_start = rd_ff[ENTRY_W-1:LEN_W];
   assign cur_len   = rd_ff[LEN_W-1:0];
   assign cur_valid = valid_ff[pidx_ff];
   assign cur_inuse = inuse_ff[pidx_ff];

   assign find_match  = cur_valid && cur_inuse && (AW'(cur_start) == AW'(addr_ff));
   assign free_other  = cur_valid && !cur_inuse && (pidx_ff != hit_idx_ff);
   assign left_match  = free_other &&
                        ((CW'(cur_start) + CW'(cur_len)) == CW'(hit_start_ff));
   assign right_match = free_other &&
                        (CW'(cur_start) == (CW'(hit_start_ff) + CW'(hit_len_ff)));
   assign fits        = cur_valid && !cur_inuse && (CW'(cur_len) >= CW'(size_ff));
   assign better      = !fit_hit_ff || (cur_start < fit_start_ff);

   assign split     = fit_hit_ff && emp_hit_ff && (CW'(fit_len_ff) > CW'(size_ff));
   assign grow_over = (CW'(top_ff) + CW'(size_ff)) > ARENA_LIM;

   assign f_idx   = lft_hit_ff ? lft_idx_ff : hit_idx_ff;
   assign f_start = lft_hit_ff ? lft_start_ff : hit_start_ff;
   assign f_len   = hit_len_ff + (lft_hit_ff ? lft_len_ff : '0)
                               + (rgt_hit_ff ? rgt_len_ff : '0);

   always_comb begin
      wr_en   = 1'b0;
      wr_idx  = f_idx;
      wr_data = {f_start, f_len};
      priority if (cmd.merge_wr) begin
         wr_en = 1'b1;
      end else if (cmd.alloc_a) begin
         wr_idx = emp_idx_ff;
         if (fit_hit_ff) begin
            wr_en   = split;
            wr_data = {START_W'(CW'(fit_start_ff) + CW'(size_ff)),
                       LEN_W'(CW'(fit_len_ff) - CW'(size_ff))};
         end else begin
            wr_en   = !grow_over && emp_hit_ff;
            wr_data = {START_W'(top_ff), LEN_W'(size_ff)};
         end
      end else if (cmd.alloc_b) begin
         wr_en   = 1'b1;
         wr_idx  = fit_idx_ff;
         wr_data = {fit_start_ff, LEN_W'(size_ff)};
      end
   end

   // memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      if (iss_ff) begin
         rd_ff <= mem[cnt_ff];
      end
   end

   // request latch
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff      <= req_kind;
         size_ff      <= size_in;
         addr_ff      <= req_addr;
         size_zero_ff <= (req_size == '0);
      end
      if (cmd.scan_start) begin
         mode_ff <= cmd.mode;
      end
      pidx_ff <= cnt_ff;
   end

   // scan counter
   always_ff @(posedge clock) begin
      if (reset) begin
         iss_ff <= 1'b0;
         pv_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         pv_ff <= iss_ff;
         if (cmd.scan_start) begin
            iss_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (iss_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LAST_IDX) begin
               iss_ff <= 1'b0;
            end
         end
      end
   end

   // trackers
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff     <= 1'b0;
         lft_hit_ff <= 1'b0;
         rgt_hit_ff <= 1'b0;
         fit_hit_ff <= 1'b0;
         emp_hit_ff <= 1'b0;
      end else if (cmd.scan_start) begin
         if (cmd.mode == ffa_pkg::SCAN_FIND) begin
            hit_ff <= 1'b0;
         end
         lft_hit_ff <= 1'b0;
         rgt_hit_ff <= 1'b0;
         fit_hit_ff <= 1'b0;
         emp_hit_ff <= 1'b0;
      end else if (pv_ff) begin
         unique case (mode_ff)
            ffa_pkg::SCAN_FIND: begin
               if (find_match && !hit_ff) begin
                  hit_ff       <= 1'b1;
                  hit_idx_ff   <= pidx_ff;
                  hit_start_ff <= cur_start;
                  hit_len_ff   <= cur_len;
               end
            end
            ffa_pkg::SCAN_MERGE: begin
               if (left_match && !lft_hit_ff) begin
                  lft_hit_ff   <= 1'b1;
                  lft_idx_ff   <= pidx_ff;
                  lft_start_ff <= cur_start;
                  lft_len_ff   <= cur_len;
               end
               if (right_match && !rgt_hit_ff) begin
                  rgt_hit_ff <= 1'b1;
                  rgt_idx_ff <= pidx_ff;
                  rgt_len_ff <= cur_len;
               end
            end
            ffa_pkg::SCAN_ALLOC: begin
               if (fits && better) begin
                  fit_hit_ff   <= 1'b1;
                  fit_idx_ff   <= pidx_ff;
                  fit_start_ff <= cur_start;
                  fit_len_ff   <= cur_len;
               end
               if (!cur_valid && !emp_hit_ff) begin
                  emp_hit_ff <= 1'b1;
                  emp_idx_ff <= pidx_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // table flags, arena top, result
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         inuse_ff      <= '0;
         top_ff        <= '0;
         res_grant_ff  <= '0;
         res_status_ff <= ffa_pkg::ST_OK;
      end else begin
         if (cmd.set_res) begin
            res_grant_ff  <= '0;
            res_status_ff <= cmd.res_code;
         end
         if (cmd.merge_wr) begin
            inuse_ff[hit_idx_ff] <= 1'b0;
            if (lft_hit_ff) begin
               valid_ff[hit_idx_ff] <= 1'b0;
            end
            if (rgt_hit_ff) begin
               valid_ff[rgt_idx_ff] <= 1'b0;
            end
         end
         if (cmd.alloc_a) begin
            priority if (fit_hit_ff) begin
               inuse_ff[fit_idx_ff] <= 1'b1;
               res_grant_ff         <= ffa_pkg::ADDR_W'(fit_start_ff);
               res_status_ff        <= ffa_pkg::ST_OK;
               if (split) begin
                  valid_ff[emp_idx_ff] <= 1'b1;
                  inuse_ff[emp_idx_ff] <= 1'b0;
               end
            end else if (grow_over) begin
               res_grant_ff  <= '0;
               res_status_ff <= ffa_pkg::ST_ARENA_FULL;
            end else if (!emp_hit_ff) begin
               res_grant_ff  <= '0;
               res_status_ff <= ffa_pkg::ST_TABLE_FULL;
            end else begin
               valid_ff[emp_idx_ff] <= 1'b1;
               inuse_ff[emp_idx_ff] <= 1'b1;
               top_ff               <= LEN_W'(CW'(top_ff) + CW'(size_ff));
               res_grant_ff         <= ffa_pkg::ADDR_W'(top_ff);
               res_status_ff        <= ffa_pkg::ST_OK;
            end
         end
      end
   end

   assign sts.scan_done = pv_ff && (pidx_ff == LAST_IDX);
   assign sts.hit       = hit_ff;
   assign sts.kind      = kind_ff;
   assign sts.size_zero = size_zero_ff;
   assign sts.split     = split;

   assign res_grant  = res_grant_ff;
   assign res_status = res_status_ff;

   `FFA_ASSERT_IMPL(a_no_grant_on_error, res_status_ff != ffa_pkg::ST_OK, res_grant_ff == '0, "grant with error status")
   `FFA_ASSERT_IMPL(a_split_slot_distinct, cmd.alloc_b, emp_idx_ff != fit_idx_ff, "split into fitted entry")
   `FFA_ASSERT_IMPL(a_merge_needs_hit, cmd.merge_wr, hit_ff, "merge without matched entry")
   `FFA_ASSERT_NEXT(a_scan_runs, cmd.scan_start, iss_ff && (cnt_ff == '0), "scan did not start")

endmodule

### hdl/first_fit_block_allocator.sv
// Latency: alloc runs an alloc scan, free a find and a merge scan, realloc
//   all three; a zero-size alloc skips the scans, and a miss skips the rest.
// Throughput: one request at a time; it is bounded by table scans that
//   read one segment entry per cycle through the single table read port.
// Reset: synchronous, active high; clears all valid/in-use flags, arena top,
//   controller state, result and response valid. No clearing pass is needed.
// ----------------------------------------------------------------------------
// first_fit_block_allocator - first fit arena allocator with split and merge
// Sequencer plus segment-table datapath; response held in an output register.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
   parameter int ARENA_BYTES  = 65536,
   parameter int MAX_SEGMENTS = 64
) (
   input  logic       clock,
   input  logic       reset,
   ffa_req_if.sink    req_chan,
   ffa_rsp_if.source  rsp_chan
);

   ffa_pkg::cmd_type cmd;
   ffa_pkg::sts_type sts;

   logic [ffa_pkg::ADDR_W-1:0]   res_grant;
   logic [ffa_pkg::STATUS_W-1:0] res_status;

   // response register: one beat parked here while the next request runs
   logic                         rsp_valid_ff;
   logic [ffa_pkg::ADDR_W-1:0]   rsp_grant_ff;
   logic [ffa_pkg::STATUS_W-1:0] rsp_status_ff;
   logic                         out_free;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   ffa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .out_free  (out_free),
      .sts       (sts),
      .cmd       (cmd)
   );

   ffa_dp #(
      .ARENA_BYTES  (ARENA_BYTES),
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_kind   (req_chan.kind),
      .req_size   (req_chan.req_size),
      .req_addr   (req_chan.req_addr),
      .res_grant  (res_grant),
      .res_status (res_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // payload only moves on a load
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_grant_ff  <= res_grant;
         rsp_status_ff <= res_status;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.grant_addr = rsp_grant_ff;
   assign rsp_chan.status     = rsp_status_ff;

endmodule
